/* src/tfhd_pkg.sv */
// Shared types and constants for the length-prefixed frame header deframer.
package tfhd_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER      = 2'd0,
		KIND_PAYLOAD     = 2'd1,
		KIND_BAD_HDR_LEN = 2'd2,
		KIND_BAD_PKT_LEN = 2'd3
	} kind_t;

	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [15:0] version;
		logic [31:0] cmd_id;
		logic [31:0] seq_no;
		logic [31:0] payload_len;
		logic [7:0]  data_byte;
		logic        last_of_frame;
	} result_t;

	localparam int unsigned PHASE_W = 5;

	// Byte positions within a frame
	localparam logic [PHASE_W-1:0] PH_PKT_END   = 5'd3;
	localparam logic [PHASE_W-1:0] PH_HDR_FIRST = 5'd4;
	localparam logic [PHASE_W-1:0] PH_HDR_LAST  = 5'd5;
	localparam logic [PHASE_W-1:0] PH_VER_END   = 5'd7;
	localparam logic [PHASE_W-1:0] PH_CMD_END   = 5'd11;
	localparam logic [PHASE_W-1:0] PH_SEQ_END   = 5'd15;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD   = 5'd16;
	localparam logic [PHASE_W-1:0] PH_START     = 5'd0;
	localparam logic [PHASE_W-1:0] PH_SECOND    = 5'd1;

	localparam logic [15:0] HDR_LEN_OK  = 16'd10;
	localparam logic [31:0] MIN_PKT_LEN = 32'd12;

endpackage

/* src/tcp_frame_header_deframer_core.sv */
// Top level of the length-prefixed frame header deframer.
// Datapath: each byte is held in the input register, the parser forms its result
// combinationally, and the result register loads that result.
// Throughput: one byte per cycle; the input register moves on whenever the
// result register is empty or being taken in the same cycle.
// Reset: arst_n clears the byte phase, field registers and both valid flags.
module tcp_frame_header_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [15:0] version,
	output logic [31:0] cmd_id,
	output logic [31:0] seq_no,
	output logic [31:0] payload_len,
	output logic [7:0]  data_byte,
	output logic        last_of_frame
);

	logic              in_valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              out_valid_q;
	tfhd_pkg::result_t res;
	tfhd_pkg::result_t res_q;
	logic              out_free;
	logic              step;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = in_valid_s1 && out_free;
	assign in_stall = in_valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	tfhd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte_s1 (rx_byte_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign version       = res_q.version;
	assign cmd_id        = res_q.cmd_id;
	assign seq_no        = res_q.seq_no;
	assign payload_len   = res_q.payload_len;
	assign data_byte     = res_q.data_byte;
	assign last_of_frame = res_q.last_of_frame;

`ifndef NO_ASSERTIONS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.kind == tfhd_pkg::KIND_BAD_HDR_LEN ||
		res_q.kind == tfhd_pkg::KIND_BAD_PKT_LEN) |-> res_q.last_of_frame)
		else $error("error result without end of frame");

	a_err_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.kind == tfhd_pkg::KIND_BAD_HDR_LEN ||
		res_q.kind == tfhd_pkg::KIND_BAD_PKT_LEN) |-> res_q.payload_len == 32'd0)
		else $error("error result carries a payload length");

	a_empty_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == tfhd_pkg::KIND_HEADER &&
		res_q.payload_len == 32'd0 |-> res_q.last_of_frame)
		else $error("empty frame header not marked last");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with an empty result register");
`endif

endmodule

/* src/tfhd_parse.sv */
// Frame parser: field accumulators, byte phase and the result for the current byte.
module tfhd_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte_s1,
	output tfhd_pkg::result_t  res
);

	logic [tfhd_pkg::PHASE_W-1:0] ph_q, ph_d;
	logic [31:0] pkt_q, pkt_d;
	logic [15:0] hdr_q, hdr_d;
	logic [15:0] ver_q, ver_d;
	logic [31:0] cmd_q, cmd_d;
	logic [31:0] seq_q, seq_d;
	logic [31:0] plen_q, plen_d;
	logic [31:0] rem_q, rem_d;
	logic [15:0] hdr_new;
	logic [31:0] seq_new;

	assign hdr_new = {hdr_q[7:0], rx_byte_s1};
	assign seq_new = {seq_q[23:0], rx_byte_s1};

	always_comb begin
		ph_d   = ph_q;
		pkt_d  = pkt_q;
		hdr_d  = hdr_q;
		ver_d  = ver_q;
		cmd_d  = cmd_q;
		seq_d  = seq_q;
		plen_d = plen_q;
		rem_d  = rem_q;
		res    = '0;
		res.kind = tfhd_pkg::KIND_HEADER;

		// A field register shifts in one byte at a time; after its last byte
		// every older bit has been pushed out.
		if (ph_q <= tfhd_pkg::PH_PKT_END || ph_q > tfhd_pkg::PH_PAYLOAD) begin
			pkt_d = {pkt_q[23:0], rx_byte_s1};
			ph_d  = (ph_q > tfhd_pkg::PH_PAYLOAD) ? tfhd_pkg::PH_SECOND
				: tfhd_pkg::PHASE_W'(ph_q + 5'd1);
		end else if (ph_q == tfhd_pkg::PH_HDR_FIRST) begin
			hdr_d = hdr_new;
			ph_d  = tfhd_pkg::PH_HDR_LAST;
		end else if (ph_q == tfhd_pkg::PH_HDR_LAST) begin
			hdr_d  = hdr_new;
			plen_d = pkt_q - tfhd_pkg::MIN_PKT_LEN;
			if (hdr_new != tfhd_pkg::HDR_LEN_OK) begin
				ph_d              = tfhd_pkg::PH_START;
				res.emit          = 1'b1;
				res.kind          = tfhd_pkg::KIND_BAD_HDR_LEN;
				res.last_of_frame = 1'b1;
			end else if (pkt_q < tfhd_pkg::MIN_PKT_LEN) begin
				ph_d              = tfhd_pkg::PH_START;
				res.emit          = 1'b1;
				res.kind          = tfhd_pkg::KIND_BAD_PKT_LEN;
				res.last_of_frame = 1'b1;
			end else begin
				ph_d = tfhd_pkg::PHASE_W'(ph_q + 5'd1);
			end
		end else if (ph_q <= tfhd_pkg::PH_VER_END) begin
			ver_d = {ver_q[7:0], rx_byte_s1};
			ph_d  = tfhd_pkg::PHASE_W'(ph_q + 5'd1);
		end else if (ph_q <= tfhd_pkg::PH_CMD_END) begin
			cmd_d = {cmd_q[23:0], rx_byte_s1};
			ph_d  = tfhd_pkg::PHASE_W'(ph_q + 5'd1);
		end else if (ph_q < tfhd_pkg::PH_SEQ_END) begin
			seq_d = seq_new;
			ph_d  = tfhd_pkg::PHASE_W'(ph_q + 5'd1);
		end else if (ph_q == tfhd_pkg::PH_SEQ_END) begin
			seq_d             = seq_new;
			rem_d             = plen_q;
			res.emit          = 1'b1;
			res.kind          = tfhd_pkg::KIND_HEADER;
			res.version       = ver_q;
			res.cmd_id        = cmd_q;
			res.seq_no        = seq_new;
			res.payload_len   = plen_q;
			res.last_of_frame = (plen_q == 32'd0);
			ph_d = (plen_q == 32'd0) ? tfhd_pkg::PH_START : tfhd_pkg::PH_PAYLOAD;
		end else begin
			// payload: count down the bytes still owed
			rem_d             = rem_q - 32'd1;
			res.emit          = 1'b1;
			res.kind          = tfhd_pkg::KIND_PAYLOAD;
			res.version       = ver_q;
			res.cmd_id        = cmd_q;
			res.seq_no        = seq_q;
			res.payload_len   = plen_q;
			res.data_byte     = rx_byte_s1;
			res.last_of_frame = (rem_q == 32'd1);
			ph_d = (rem_q == 32'd1) ? tfhd_pkg::PH_START : tfhd_pkg::PH_PAYLOAD;
		end

		if (!step) begin
			res.emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= tfhd_pkg::PH_START;
			pkt_q  <= '0;
			hdr_q  <= '0;
			ver_q  <= '0;
			cmd_q  <= '0;
			seq_q  <= '0;
			plen_q <= '0;
			rem_q  <= '0;
		end else if (step) begin
			ph_q   <= ph_d;
			pkt_q  <= pkt_d;
			hdr_q  <= hdr_d;
			ver_q  <= ver_d;
			cmd_q  <= cmd_d;
			seq_q  <= seq_d;
			plen_q <= plen_d;
			rem_q  <= rem_d;
		end
	end

endmodule
